>>> rtl/bba_pkg.sv
// bitmap block allocator package: request codes and transfer structs
// no dependencies; used by bitmap_block_allocator
package bba_pkg;

    localparam int INDEX_BITS = 14;
    localparam int SUM_BITS   = 32;
    localparam int SUM_SHIFT  = 5;

    localparam logic [1:0] REQ_FIND = 2'd0;
    localparam logic [1:0] REQ_BUSY = 2'd1;
    localparam logic [1:0] REQ_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [INDEX_BITS-1:0] block_index;
    } t_bba_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] free_block;
        logic                  none_free;
    } t_bba_rsp;

endpackage

>>> rtl/bba_ram.sv
// generic single-port synchronous ram with a registered read
// no dependencies
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bitmap_block_allocator.sv
// bitmap free-block allocator top level: block bitmap plus per-word full summary
// depends on bba_pkg and bba_ram
//
// Use: drive i_cmd and raise start; the command transfer happens at a rising
// edge with start high and busy low. Exactly one result per command appears
// on o_result with o_valid high for one cycle; the receiver cannot stall it.
// A find command reports the lowest free block and claims nothing; mark busy
// and mark free commands echo block_index. Indices beyond the bitmap and the
// unused command code change nothing.
// Find: walks the summary ram one 32-word summary entry at a time, up to the
// first one with a free word, then reads that word.
// A mark splits the index into word and bit with a reciprocal multiply, then
// reads and writes the bitmap word and its summary entry.
// Out-of-range marks and unused codes are answered in the cycle after the transfer.
// One command at a time; for a find or an in-range mark busy stays high until its result is shown.
// Reset: a clearing pass writes zero to every bitmap word and summary entry,
// one word per cycle, with busy high.
module bitmap_block_allocator #(
    parameter int WORDS     = 512,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bba_pkg::t_bba_req i_cmd,
    output logic              busy,
    output logic              o_valid,
    output bba_pkg::t_bba_rsp o_result
);

    localparam int IB        = bba_pkg::INDEX_BITS;
    localparam int SB        = bba_pkg::SUM_BITS;
    localparam int SS        = bba_pkg::SUM_SHIFT;
    localparam int WA        = $clog2(WORDS > 1 ? WORDS : 2);
    localparam int SUM_DEPTH = (WORDS + SB - 1) / SB;
    localparam int SA        = $clog2(SUM_DEPTH > 1 ? SUM_DEPTH : 2);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int RS        = IB + BW;
    localparam int MW        = IB + 2;
    localparam int RM        = ((1 << RS) + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL     = WORDS * WORD_BITS;
    localparam int LIMIT     = TOTAL < (1 << IB) ? TOTAL : (1 << IB);
    localparam int LAST_WORD = (LIMIT - 1) / WORD_BITS;
    localparam int LAST_BITS = LIMIT - LAST_WORD * WORD_BITS;
    localparam int LAST_SUM  = LAST_WORD / SB;
    localparam int LAST_SBIT = LAST_WORD % SB;

    localparam logic [IB:0]          LIMIT_X  = (IB+1)'(LIMIT);
    localparam logic [WORD_BITS-1:0] WORD_PAD =
        ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
    localparam logic [SB-1:0]        SUM_PAD  = ~({SB{1'b1}} >> (SB - 1 - LAST_SBIT));

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_WREAD,
        S_WMOD,
        S_SMOD,
        S_FSUM,
        S_FSCHK,
        S_FWORD,
        S_FWCHK
    } t_state;

    t_state                r_state;
    logic [WA-1:0]         r_clr;
    logic [1:0]            r_req;
    logic [IB-1:0]         r_idx;
    logic [WA-1:0]         r_word;
    logic [BW-1:0]         r_bit;
    logic                  r_full;
    logic [SA-1:0]         r_sidx;
    logic                  r_valid;
    bba_pkg::t_bba_rsp     r_result;

    logic                  w_we;
    logic [WA-1:0]         w_addr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [WORD_BITS-1:0]  w_rdata;
    logic                  s_we;
    logic [SA-1:0]         s_addr;
    logic [SB-1:0]         s_wdata;
    logic [SB-1:0]         s_rdata;

    logic [IB+MW-1:0]      div_prod;
    logic [IB-1:0]         div_quo;
    logic [BW-1:0]         div_rem;
    logic [WA+SS-1:0]      word_ext;
    logic [WORD_BITS-1:0]  word_mod;
    logic [SB-1:0]         sum_mod;
    logic [SB-1:0]         sum_masked;
    logic                  sum_zero;
    logic [SS-1:0]         sum_pos;
    logic [WORD_BITS-1:0]  word_masked;
    logic                  word_zero;
    logic [BW-1:0]         word_pos;
    logic [WA+SS-1:0]      found_word;
    logic [IB-1:0]         found_block;

    bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    bba_ram #(.WIDTH(SB), .DEPTH(SUM_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_addr  (s_addr),
        .i_wdata (s_wdata),
        .o_rdata (s_rdata)
    );

    // word and bit split by reciprocal multiply
    always_comb begin
        div_prod = (IB+MW)'(r_idx) * (IB+MW)'(RM);
        div_quo  = IB'(div_prod >> RS);
        div_rem  = BW'(r_idx - IB'(int'(div_quo) * WORD_BITS));
    end

    // bitmap word and summary entry updates
    always_comb begin
        word_ext = {{SS{1'b0}}, r_word};
        word_mod = w_rdata;
        word_mod[r_bit] = (r_req == bba_pkg::REQ_BUSY);
        sum_mod = s_rdata;
        sum_mod[word_ext[SS-1:0]] = r_full;
    end

    // first free word in a summary entry, lowest position wins
    always_comb begin
        sum_masked = (int'(r_sidx) == LAST_SUM) ? (s_rdata | SUM_PAD) : s_rdata;
        sum_zero   = 1'b0;
        sum_pos    = '0;
        for (int j = SB - 1; j >= 0; j--) begin
            if (!sum_masked[j]) begin
                sum_zero = 1'b1;
                sum_pos  = SS'(j);
            end
        end
        found_word = (WA+SS)'({{(WA+SS){1'b0}}, r_sidx, sum_pos});
    end

    // first free bit in a bitmap word
    always_comb begin
        word_masked = (int'(r_word) == LAST_WORD) ? (w_rdata | WORD_PAD) : w_rdata;
        word_zero   = 1'b0;
        word_pos    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word_masked[b]) begin
                word_zero = 1'b1;
                word_pos  = BW'(b);
            end
        end
        found_block = IB'(int'(r_word) * WORD_BITS + int'(word_pos));
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_word;
        w_wdata = word_mod;
        s_we    = 1'b0;
        s_addr  = word_ext[SA+SS-1:SS];
        s_wdata = sum_mod;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr;
                w_wdata = '0;
                s_we    = int'(r_clr) < SUM_DEPTH;
                s_addr  = SA'(r_clr);
                s_wdata = '0;
            end
            S_WMOD: begin
                w_we = 1'b1;
            end
            S_SMOD: begin
                s_we = 1'b1;
            end
            S_FSUM: begin
                s_addr = r_sidx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == WORDS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_cmd.req_type;
                        r_idx  <= i_cmd.block_index;
                        r_sidx <= '0;
                        if (i_cmd.req_type == bba_pkg::REQ_FIND) begin
                            r_state <= S_FSUM;
                        end else if ((i_cmd.req_type == bba_pkg::REQ_BUSY ||
                                      i_cmd.req_type == bba_pkg::REQ_FREE) &&
                                     {1'b0, i_cmd.block_index} < LIMIT_X) begin
                            r_state <= S_DIV;
                        end else begin
                            r_valid             <= 1'b1;
                            r_result.free_block <= i_cmd.block_index;
                            r_result.none_free  <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    r_word  <= div_quo[WA-1:0];
                    r_bit   <= div_rem;
                    r_state <= S_WREAD;
                end
                S_WREAD: begin
                    r_state <= S_WMOD;
                end
                S_WMOD: begin
                    r_full  <= &word_mod;
                    r_state <= S_SMOD;
                end
                S_SMOD: begin
                    r_valid             <= 1'b1;
                    r_result.free_block <= r_idx;
                    r_result.none_free  <= 1'b0;
                    r_state             <= S_IDLE;
                end
                S_FSUM: begin
                    r_state <= S_FSCHK;
                end
                S_FSCHK: begin
                    if (sum_zero) begin
                        r_word  <= found_word[WA-1:0];
                        r_state <= S_FWORD;
                    end else if (int'(r_sidx) == LAST_SUM) begin
                        r_valid             <= 1'b1;
                        r_result.free_block <= '0;
                        r_result.none_free  <= 1'b1;
                        r_state             <= S_IDLE;
                    end else begin
                        r_sidx  <= r_sidx + 1'b1;
                        r_state <= S_FSUM;
                    end
                end
                S_FWORD: begin
                    r_state <= S_FWCHK;
                end
                S_FWCHK: begin
                    r_valid <= 1'b1;
                    if (word_zero) begin
                        r_result.free_block <= found_block;
                        r_result.none_free  <= 1'b0;
                    end else begin
                        r_result.free_block <= '0;
                        r_result.none_free  <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> verif/tb_bitmap_block_allocator.sv
// self-checking testbench for bitmap_block_allocator: a table of commands, a deep-search pass
// and random find, claim and free traffic, checked against an in-bench bitmap predictor
// depends on bba_pkg and bitmap_block_allocator
module tb_bitmap_block_allocator;

    localparam int INDEX_BITS   = bba_pkg::INDEX_BITS;
    localparam int WORDS        = 512;
    localparam int WORD_BITS    = 32;
    localparam int TOTAL_BLOCKS = WORDS * WORD_BITS;
    localparam int INDEX_MAX    = (1 << INDEX_BITS) - 1;
    localparam int SEARCH_LIMIT = (TOTAL_BLOCKS < INDEX_MAX + 1) ? TOTAL_BLOCKS : INDEX_MAX + 1;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_ITEMS = 470;
    localparam int DEEP_BLOCKS  = 128;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [INDEX_BITS-1:0] block_index;
        logic                  typed;
        logic [INDEX_BITS-1:0] exp_block;
        logic                  exp_none;
    } t_cmd_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    bba_pkg::t_bba_req i_cmd;
    logic              busy;
    logic              o_valid;
    bba_pkg::t_bba_rsp o_result;

    logic [WORD_BITS-1:0] busy_words [WORDS];
    bba_pkg::t_bba_rsp    pending_rsp [$];
    int                   fail_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 0;

    // after reset every block is free
    t_cmd_row cmd_table [0:19] = '{
        '{bba_pkg::REQ_FIND, 14'd0,     1'b1, 14'd0,     1'b0},
        '{bba_pkg::REQ_BUSY, 14'd0,     1'b1, 14'd0,     1'b0},
        '{bba_pkg::REQ_FIND, 14'd0,     1'b1, 14'd1,     1'b0},
        '{bba_pkg::REQ_BUSY, 14'd16383, 1'b1, 14'd16383, 1'b0},
        '{bba_pkg::REQ_BUSY, 14'd1,     1'b1, 14'd1,     1'b0},
        '{bba_pkg::REQ_BUSY, 14'd2,     1'b1, 14'd2,     1'b0},
        '{bba_pkg::REQ_FIND, 14'd16383, 1'b0, 14'd0,     1'b0},
        '{bba_pkg::REQ_FREE, 14'd1,     1'b1, 14'd1,     1'b0},
        '{bba_pkg::REQ_FIND, 14'd0,     1'b1, 14'd1,     1'b0},
        '{REQ_UNUSED,        14'd5,     1'b1, 14'd5,     1'b0},
        '{REQ_UNUSED,        14'd16383, 1'b1, 14'd16383, 1'b0},
        '{bba_pkg::REQ_FREE, 14'd16383, 1'b1, 14'd16383, 1'b0},
        '{bba_pkg::REQ_BUSY, 14'd31,    1'b1, 14'd31,    1'b0},
        '{bba_pkg::REQ_BUSY, 14'd32,    1'b1, 14'd32,    1'b0},
        '{bba_pkg::REQ_FREE, 14'd0,     1'b1, 14'd0,     1'b0},
        '{bba_pkg::REQ_FIND, 14'h1555,  1'b0, 14'd0,     1'b0},
        '{bba_pkg::REQ_BUSY, 14'h2aaa,  1'b1, 14'h2aaa,  1'b0},
        '{bba_pkg::REQ_FREE, 14'h1555,  1'b1, 14'h1555,  1'b0},
        '{bba_pkg::REQ_FREE, 14'h2aaa,  1'b1, 14'h2aaa,  1'b0},
        '{bba_pkg::REQ_FIND, 14'd0,     1'b0, 14'd0,     1'b0}
    };

    bitmap_block_allocator #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit lowest_free(output logic [INDEX_BITS-1:0] blk);
        blk = '0;
        for (int w = 0; w < WORDS; w++) begin
            if (w * WORD_BITS >= SEARCH_LIMIT)
                break;
            if (~busy_words[w] != '0) begin
                for (int b = 0; b < WORD_BITS; b++) begin
                    if (!busy_words[w][b] && w * WORD_BITS + b < SEARCH_LIMIT) begin
                        blk = INDEX_BITS'(w * WORD_BITS + b);
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // applies one command to the bitmap copy and returns its answer
    function automatic bba_pkg::t_bba_rsp allocator_answer(bba_pkg::t_bba_req cmd);
        bba_pkg::t_bba_rsp     rsp;
        logic [INDEX_BITS-1:0] blk;
        int                    n;
        rsp.free_block = cmd.block_index;
        rsp.none_free  = 1'b0;
        n = int'(cmd.block_index);
        case (cmd.req_type)
            bba_pkg::REQ_FIND: begin
                if (lowest_free(blk)) begin
                    rsp.free_block = blk;
                end else begin
                    rsp.free_block = '0;
                    rsp.none_free  = 1'b1;
                end
            end
            bba_pkg::REQ_BUSY: begin
                if (n < TOTAL_BLOCKS)
                    busy_words[n / WORD_BITS][n % WORD_BITS] = 1'b1;
            end
            bba_pkg::REQ_FREE: begin
                if (n < TOTAL_BLOCKS)
                    busy_words[n / WORD_BITS][n % WORD_BITS] = 1'b0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic issue(input logic [1:0] req, input int idx, input bit typed = 1'b0,
                         input logic [INDEX_BITS-1:0] exp_block = '0,
                         input logic exp_none = 1'b0);
        bba_pkg::t_bba_req cmd;
        bba_pkg::t_bba_rsp rsp;
        int                gap;
        cmd.req_type    = req;
        cmd.block_index = INDEX_BITS'(idx);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 15);
        end
        i_cmd <= cmd;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        rsp = allocator_answer(cmd);
        if (typed) begin
            rsp.free_block = exp_block;
            rsp.none_free  = exp_none;
        end
        pending_rsp.push_back(rsp);
    endtask

    task automatic random_traffic(input int target);
        int                    sent;
        int                    sel;
        int                    near;
        logic [INDEX_BITS-1:0] frontier;
        logic [INDEX_BITS-1:0] blk;
        sent = 0;
        while (sent < target) begin
            if (!lowest_free(frontier))
                frontier = INDEX_BITS'(INDEX_MAX);
            near = int'(frontier) + $urandom_range(0, 40);
            if (near > INDEX_MAX)
                near = INDEX_MAX;
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                // find then claim the reported block
                issue(bba_pkg::REQ_FIND, $urandom_range(0, INDEX_MAX));
                if (!lowest_free(blk))
                    blk = INDEX_BITS'($urandom_range(0, INDEX_MAX));
                issue(bba_pkg::REQ_BUSY, int'(blk));
                sent += 2;
            end else begin
                if (sel < 45)
                    issue(bba_pkg::REQ_FREE, $urandom_range(0, INDEX_MAX));
                else if (sel < 55)
                    issue(bba_pkg::REQ_FREE, $urandom_range(0, near));
                else if (sel < 70)
                    issue(bba_pkg::REQ_BUSY, $urandom_range(0, INDEX_MAX));
                else if (sel < 80)
                    issue(bba_pkg::REQ_BUSY, near);
                else if (sel < 95)
                    issue(bba_pkg::REQ_FIND, $urandom_range(0, INDEX_MAX));
                else
                    issue(REQ_UNUSED, $urandom_range(0, INDEX_MAX));
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_bitmap_block_allocator NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        bba_pkg::t_bba_rsp want;
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result: free_block %0d none_free %0d",
                       o_result.free_block, o_result.none_free);
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_result.free_block !== want.free_block) begin
                    $error("free_block: expected %0d, actual %0d",
                           want.free_block, o_result.free_block);
                    fail_count++;
                end
                if (o_result.none_free !== want.none_free) begin
                    $error("none_free: expected %0d, actual %0d",
                           want.none_free, o_result.none_free);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int w = 0; w < WORDS; w++)
            busy_words[w] = '0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[r])
            issue(cmd_table[r].req_type, int'(cmd_table[r].block_index), cmd_table[r].typed,
                  cmd_table[r].exp_block, cmd_table[r].exp_none);

        // hold off until the block has drained
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);

        random_traffic(RANDOM_ITEMS);

        // first words busy, then deeper searches
        for (int b = 0; b < DEEP_BLOCKS; b++)
            issue(bba_pkg::REQ_BUSY, b);
        issue(bba_pkg::REQ_FIND, 0);
        issue(bba_pkg::REQ_FREE, DEEP_BLOCKS - 1, 1'b1, INDEX_BITS'(DEEP_BLOCKS - 1), 1'b0);
        issue(bba_pkg::REQ_FIND, 0, 1'b1, INDEX_BITS'(DEEP_BLOCKS - 1), 1'b0);

        random_traffic(RANDOM_ITEMS);

        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_bitmap_block_allocator OK");
        else
            $display("tb_bitmap_block_allocator NOT OK");
        $finish;
    end

endmodule
